/* hw/rtl/rsa_pkg.sv */
// Shared types and constants for the ring slot allocator with fence reclaim.
package rsa_pkg;

  localparam int HEAD_W   = 64;
  localparam int FENCE_W  = 64;
  localparam int CAP_W    = 17;
  localparam int BASE_W   = 20;
  localparam int SLOT_W   = 21;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 40;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOTS     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MARKERS_FULL = 2'd3;

  localparam logic CFG_RING_BASE     = 1'b0;
  localparam logic CFG_RING_CAPACITY = 1'b1;

  typedef struct packed {
    logic [FENCE_W-1:0] fence;
    logic [HEAD_W-1:0]  head;
  } marker_t;

  typedef struct packed {
    logic start;
    logic flush;
  } mod_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

/* hw/rtl/rsa_marker_mem.sv */
// Frame marker memory: one write port and one registered read port.
module rsa_marker_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  rsa_pkg::marker_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output rsa_pkg::marker_t rd_data
);

  rsa_pkg::marker_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/rsa_mod_unit.sv */
// Bit-serial remainder of the head total by the ring capacity.
module rsa_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsa_pkg::mod_ctrl_t         ctrl,
  input  logic [rsa_pkg::HEAD_W-1:0] dividend,
  input  logic [rsa_pkg::CAP_W-1:0]  divisor,
  output rsa_pkg::mod_stat_t         stat,
  output logic [rsa_pkg::CAP_W-1:0]  remainder
);

  localparam int CW = $clog2(rsa_pkg::HEAD_W);
  localparam logic [CW-1:0] LAST_STEP = CW'(rsa_pkg::HEAD_W - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [CW-1:0]              cnt_r;
  logic [rsa_pkg::CAP_W-1:0]  rem_r;
  logic [rsa_pkg::HEAD_W-1:0] num_r;
  logic [rsa_pkg::CAP_W-1:0]  div_r;
  logic [rsa_pkg::CAP_W:0]    trial;
  logic [rsa_pkg::CAP_W:0]    rem_step;

  always_comb begin
    trial    = {rem_r, num_r[rsa_pkg::HEAD_W-1]};
    rem_step = (trial >= {1'b0, div_r}) ? trial - {1'b0, div_r} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.flush) begin
        busy_r <= 1'b0;
      end else if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      num_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[rsa_pkg::HEAD_W-2:0], 1'b0};
      rem_r <= rem_step[rsa_pkg::CAP_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

/* hw/rtl/ring_slot_allocator_fence_reclaim.sv */
// Top level of the ring slot allocator with fence-based reclaim.
//
//   port group   dir  fields (low bit first)
//   in_*         in   tuser: kind; tdata: slot_count, frame_fence, completed_fence
//   out_*        out  tdata: status, slot_index, in_flight
//   cfg_*        in   index 0 ring_base, index 1 ring_capacity
//
// An allocate beat is worked in S_ALLOC and its result is registered at the output.
// An end-of-frame beat steps through S_CHK, then S_RD and S_CHK for each retired marker,
// then S_MARK, one marker read from the marker memory per retire step.
// A write of a nonzero capacity holds off input while a bit-serial remainder
// rebuilds the head position.
// Reset is synchronous; the marker memory is not cleared, its fill count guards it.
// A stalled output holds its result; one more beat is taken and waits until it leaves.
module ring_slot_allocator_fence_reclaim #(
  parameter int MARKER_DEPTH = 8,
  parameter int MAX_SLOTS    = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // slot_count, frame_fence, completed_fence
  input  logic [rsa_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status, slot_index, in_flight
  output logic [rsa_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [rsa_pkg::BASE_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(MARKER_DEPTH);
  localparam int FW = $clog2(MARKER_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MARKER_DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(MARKER_DEPTH);
  localparam logic [rsa_pkg::CAP_W-1:0] CAP_LIMIT =
    (MAX_SLOTS > 131071) ? 17'h1FFFF : 17'(MAX_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [rsa_pkg::BASE_W-1:0]     base_r;
  logic [rsa_pkg::CAP_W-1:0]      cap_r;
  logic [rsa_pkg::HEAD_W-1:0]     head_r, head_nxt;
  logic [rsa_pkg::CAP_W-1:0]      inflight_r, inflight_nxt;
  logic [rsa_pkg::CAP_W-1:0]      phys_r, phys_nxt;
  logic                           dirty_r, dirty_nxt;
  logic [AW-1:0]                  rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]                  wr_ptr_r, wr_ptr_nxt;
  logic [FW-1:0]                  fill_r, fill_nxt;
  logic [rsa_pkg::HEAD_W-1:0]     last_head_r;
  logic                           kind_r;
  logic [rsa_pkg::CAP_W-1:0]      count_r;
  logic [rsa_pkg::FENCE_W-1:0]    ffence_r;
  logic [rsa_pkg::FENCE_W-1:0]    cfence_r;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [rsa_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [rsa_pkg::CAP_W-1:0]      live_cap;
  logic                           ld;
  logic                           accept;
  logic                           cap_write;
  logic [rsa_pkg::CAP_W:0]        phys_sum;
  logic                           wrap;
  logic [rsa_pkg::CAP_W-1:0]      pad;
  logic [rsa_pkg::CAP_W+1:0]      need;
  logic                           no_space;
  logic                           bad;
  logic [rsa_pkg::CAP_W-1:0]      offset;
  logic [rsa_pkg::CAP_W:0]        end_sum;
  logic [rsa_pkg::CAP_W-1:0]      phys_new;
  logic [rsa_pkg::SLOT_W-1:0]     slot;
  logic                           pop_ok;
  logic                           same_head;
  logic                           full;
  logic                           mem_wr_en;
  rsa_pkg::marker_t               mem_wr_data;
  rsa_pkg::marker_t               mem_rd_data;
  rsa_pkg::mod_ctrl_t             mod_ctrl;
  rsa_pkg::mod_stat_t             mod_stat;
  logic [rsa_pkg::CAP_W-1:0]      mod_rem;
  logic [rsa_pkg::HEAD_W-1:0]     pop_diff;

  rsa_marker_mem #(
    .DEPTH (MARKER_DEPTH),
    .AW    (AW)
  ) u_marker_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (mem_wr_data),
    .rd_addr (rd_ptr_r),
    .rd_data (mem_rd_data)
  );

  rsa_mod_unit u_mod_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mod_ctrl),
    .dividend  (head_r),
    .divisor   (live_cap),
    .stat      (mod_stat),
    .remainder (mod_rem)
  );

  assign live_cap  = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;
  assign ld        = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && !(dirty_r && (live_cap != '0));
  assign accept    = in_tvalid && in_tready;
  assign cap_write = cfg_wr_en && (cfg_index == rsa_pkg::CFG_RING_CAPACITY);

  assign mod_ctrl.flush = cap_write;
  assign mod_ctrl.start = dirty_r && (live_cap != '0) && !mod_stat.busy &&
                          !mod_stat.done && !cap_write;

  always_comb begin
    phys_sum = {1'b0, phys_r} + {1'b0, count_r};
    wrap     = phys_sum > {1'b0, live_cap};
    pad      = wrap ? live_cap - phys_r : '0;
    need     = {2'b00, inflight_r} + {2'b00, pad} + {2'b00, count_r};
    no_space = need > {2'b00, live_cap};
    bad      = (live_cap == '0) || (count_r == '0) || (count_r > live_cap);
    offset   = wrap ? '0 : phys_r;
    end_sum  = {1'b0, offset} + {1'b0, count_r};
    phys_new = (end_sum == {1'b0, live_cap}) ? '0 : end_sum[rsa_pkg::CAP_W-1:0];
    slot     = rsa_pkg::SLOT_W'(base_r) + rsa_pkg::SLOT_W'(offset);
    pop_ok   = (fill_r != '0) && (mem_rd_data.fence <= cfence_r);
    pop_diff = head_r - mem_rd_data.head;
    same_head = (fill_r != '0) && (last_head_r == head_r);
    full      = fill_r == FULL_FILL;
    mem_wr_en = (state_r == S_MARK) && ld && !same_head && !full;
    mem_wr_data.fence = ffence_r;
    mem_wr_data.head  = head_r;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    inflight_nxt   = inflight_r;
    phys_nxt       = phys_r;
    dirty_nxt      = dirty_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (mod_stat.done && !cap_write) begin
      phys_nxt  = mod_rem;
      dirty_nxt = 1'b0;
    end
    if (cap_write) begin
      dirty_nxt = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser && (live_cap != '0)) ? S_CHK : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (ld) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
          if (bad) begin
            out_tdata_nxt = {inflight_r, {rsa_pkg::SLOT_W{1'b0}}, rsa_pkg::ST_INVALID};
          end else if (no_space) begin
            out_tdata_nxt = {inflight_r, {rsa_pkg::SLOT_W{1'b0}}, rsa_pkg::ST_NO_SLOTS};
          end else begin
            head_nxt      = head_r + rsa_pkg::HEAD_W'(pad) + rsa_pkg::HEAD_W'(count_r);
            inflight_nxt  = need[rsa_pkg::CAP_W-1:0];
            phys_nxt      = phys_new;
            out_tdata_nxt = {need[rsa_pkg::CAP_W-1:0], slot, rsa_pkg::ST_OK};
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (pop_ok) begin
          inflight_nxt = pop_diff[rsa_pkg::CAP_W-1:0];
          rd_ptr_nxt   = (rd_ptr_r == LAST_ADDR) ? '0 : rd_ptr_r + 1'b1;
          fill_nxt     = fill_r - 1'b1;
          state_nxt    = S_RD;
        end else begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (ld) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
          if (!same_head && full) begin
            out_tdata_nxt = {inflight_r, {rsa_pkg::SLOT_W{1'b0}}, rsa_pkg::ST_MARKERS_FULL};
          end else begin
            out_tdata_nxt = {inflight_r, {rsa_pkg::SLOT_W{1'b0}}, rsa_pkg::ST_OK};
          end
          if (mem_wr_en) begin
            wr_ptr_nxt = (wr_ptr_r == LAST_ADDR) ? '0 : wr_ptr_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= '0;
      cap_r        <= '0;
      head_r       <= '0;
      inflight_r   <= '0;
      phys_r       <= '0;
      dirty_r      <= 1'b0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      inflight_r   <= inflight_nxt;
      phys_r       <= phys_nxt;
      dirty_r      <= dirty_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      fill_r       <= fill_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == rsa_pkg::CFG_RING_BASE) begin
          base_r <= cfg_wdata;
        end else begin
          cap_r <= cfg_wdata[rsa_pkg::CAP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    if (mem_wr_en) begin
      last_head_r <= head_r;
    end
    if (accept) begin
      kind_r   <= in_tuser;
      count_r  <= in_tdata[16:0];
      ffence_r <= in_tdata[80:17];
      cfence_r <= in_tdata[144:81];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_FILL)
    else $error("marker fill count beyond depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (fill_r < FULL_FILL))
    else $error("marker written into a full store");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a beat is in work");

  a_mod_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    mod_stat.done |-> dirty_r)
    else $error("remainder finished without a pending capacity change");

  a_kind_route: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> kind_r)
    else $error("allocate beat entered the reclaim path");
`endif

endmodule
